>>> design/assert_macros.svh
// Assertion macros used by the checker file of this block.
// No dependencies; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("same-cycle check failed");

// Next-cycle implication, disabled during reset.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

>>> design/mrfr_pkg.sv
// Shared types and constants for the multi-reader frame ring.
// No dependencies; imported by the top level and its checker.
package mrfr_pkg;

  localparam int DEPTH_DEF   = 1024;
  localparam int READERS_DEF = 4;

  localparam int MODE_W   = 3;
  localparam int CONS_W   = 2;
  localparam int SAMPLE_W = 32;
  localparam int OFFS_W   = 10;
  localparam int COUNT_W  = 11;
  localparam int STATUS_W = 2;

  typedef enum logic [MODE_W-1:0] {
    MODE_WRITE   = 3'd0,
    MODE_PEEK    = 3'd1,
    MODE_ADVANCE = 3'd2,
    MODE_ATTACH  = 3'd3,
    MODE_DETACH  = 3'd4
  } mode_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_DONE      = 2'd0,
    ST_FULL      = 2'd1,
    ST_PEEK_MISS = 2'd2,
    ST_CLAMP     = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_LOOK,
    S_SCAN,
    S_FINISH
  } state_t;

  typedef struct packed {
    logic [MODE_W-1:0]   mode;
    logic [CONS_W-1:0]   consumer;
    logic [SAMPLE_W-1:0] sample_left;
    logic [SAMPLE_W-1:0] sample_right;
    logic [OFFS_W-1:0]   frame_offset;
    logic [COUNT_W-1:0]  advance_count;
  } cmd_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [SAMPLE_W-1:0] data_left;
    logic [SAMPLE_W-1:0] data_right;
    logic [COUNT_W-1:0]  frames_available;
    logic [COUNT_W-1:0]  free_space;
    logic                reader_attached;
  } res_t;

endpackage

>>> design/multi_reader_frame_ring.sv
// Top level of the multi-reader stereo frame ring.
// Depends on mrfr_pkg (types, codes, default sizes).
//
//  channel | valid     | stall     | payload | direction
//  --------+-----------+-----------+---------+----------
//  command | cmd_valid | cmd_stall | cmd     | into block
//  result  | res_valid | res_stall | res     | out of block
//
// One item passes through capture, state lookup, a scan of the cursor memory
// that visits one reader per cycle to find the slowest attached reader, and a
// finish state that loads the result register.
// Synchronous active-high reset clears head, attach mask and control; the frame
// and cursor memories need no clearing pass (an unattached cursor is never used).
// cmd_stall is high from acceptance until the result is loaded; the result
// register holds while res_stall is high, and the next item may start meanwhile.
module multi_reader_frame_ring #(
  parameter int DEPTH   = mrfr_pkg::DEPTH_DEF,
  parameter int READERS = mrfr_pkg::READERS_DEF
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           cmd_valid,
  output logic           cmd_stall,
  input  mrfr_pkg::cmd_t cmd,
  output logic           res_valid,
  input  logic           res_stall,
  output mrfr_pkg::res_t res
);
  import mrfr_pkg::*;

  // Frame counts run modulo 2*DEPTH; a frame lives in slot (count mod DEPTH).
  localparam int CW = $clog2(2 * DEPTH);
  localparam int AW = $clog2(DEPTH);
  localparam int RW = (READERS > 1) ? $clog2(READERS) : 1;
  localparam int KW = $clog2(READERS + 1);
  localparam int WW = ((CW > COUNT_W) ? CW : COUNT_W) + 1;
  localparam logic [WW-1:0] MOD2_W  = WW'(2 * DEPTH);
  localparam logic [WW-1:0] DEPTH_W = WW'(DEPTH);

  // (a + b) mod 2*DEPTH for a, b whose sum stays below 4*DEPTH
  function automatic logic [CW-1:0] wrap_add(logic [WW-1:0] a, logic [WW-1:0] b);
    logic [WW-1:0] s;
    s = a + b;
    if (s >= MOD2_W) s = s - MOD2_W;
    return s[CW-1:0];
  endfunction

  // frames between a cursor and the head
  function automatic logic [CW-1:0] backlog_of(logic [CW-1:0] hd, logic [CW-1:0] cur);
    logic [WW-1:0] d;
    d = WW'(hd) + MOD2_W - WW'(cur);
    if (d >= MOD2_W) d = d - MOD2_W;
    return d[CW-1:0];
  endfunction

  function automatic logic [AW-1:0] slot_of(logic [CW-1:0] n);
    logic [WW-1:0] v;
    v = WW'(n);
    if (v >= DEPTH_W) v = v - DEPTH_W;
    return v[AW-1:0];
  endfunction

  // Control state
  state_t               state, state_next;
  logic [CW-1:0]        head, head_next;
  logic [READERS-1:0]   attached, attached_next;
  logic [CW-1:0]        used_max;   // largest backlog after the last item
  logic [KW-1:0]        scan_k;
  logic [CW-1:0]        scan_acc;

  // Item and result holding
  cmd_t                 cmd_q;
  status_t              status_q, status_next;
  logic                 peek_ok, peek_ok_next;
  logic [CW-1:0]        avail_q;
  logic [SAMPLE_W-1:0]  data_l, data_r;

  // Memories
  logic [2*SAMPLE_W-1:0] frame_store [DEPTH];
  logic [2*SAMPLE_W-1:0] frame_rd;
  logic [CW-1:0]         cursor_mem [READERS];
  logic [CW-1:0]         cursor_rd;

  logic                  frm_we, frm_re;
  logic [AW-1:0]         frm_waddr, frm_raddr;
  logic [2*SAMPLE_W-1:0] frm_wdata;
  logic                  cur_we;
  logic [RW-1:0]         cur_waddr, cur_raddr;
  logic [CW-1:0]         cur_wdata;

  logic cmd_accept, res_free, load_res;

  // Reader addressed by the held item and by the incoming one
  logic [RW+1:0] cons_ext, in_cons_ext;
  logic [RW-1:0] cidx, in_cidx;
  logic          cons_ok, c_att;
  logic [CW-1:0] bl_c;
  logic [WW-1:0] adv_cnt, adv_n;
  logic          full;

  // Scan of the cursor memory
  logic [KW-1:0] scan_j;
  logic [RW-1:0] j_idx;
  logic [CW-1:0] bl_j, acc_next;

  logic [WW-1:0] free_w, avail_w;

  assign cmd_accept = cmd_valid && !cmd_stall;
  assign res_free   = !res_valid || !res_stall;

  assign cons_ext    = (RW + 2)'(cmd_q.consumer);
  assign in_cons_ext = (RW + 2)'(cmd.consumer);
  assign cidx        = cons_ext[RW-1:0];
  assign in_cidx     = in_cons_ext[RW-1:0];
  assign cons_ok     = cons_ext < (RW + 2)'(READERS);
  assign c_att       = cons_ok && attached[cidx];
  assign bl_c        = c_att ? backlog_of(head, cursor_rd) : '0;
  assign full        = WW'(used_max) >= DEPTH_W;
  assign adv_cnt     = WW'(cmd_q.advance_count);
  assign adv_n       = (adv_cnt > WW'(bl_c)) ? WW'(bl_c) : adv_cnt;

  assign scan_j   = scan_k - KW'(1);
  assign j_idx    = scan_j[RW-1:0];
  assign bl_j     = attached[j_idx] ? backlog_of(head, cursor_rd) : '0;
  assign acc_next = (bl_j > scan_acc) ? bl_j : scan_acc;

  assign free_w  = DEPTH_W - WW'(scan_acc);
  assign avail_w = WW'(avail_q);

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:   if (cmd_accept) state_next = S_LOOK;
      S_LOOK:   state_next = S_SCAN;
      S_SCAN:   if (scan_k == KW'(READERS)) state_next = S_FINISH;
      S_FINISH: if (res_free) state_next = S_IDLE;
      default:  state_next = S_IDLE;
    endcase
  end

  // Outputs of the sequencer: memory ports and state updates
  always_comb begin
    cmd_stall     = 1'b1;
    cur_raddr     = in_cidx;
    cur_we        = 1'b0;
    cur_waddr     = cidx;
    cur_wdata     = head;
    frm_we        = 1'b0;
    frm_re        = 1'b0;
    frm_waddr     = slot_of(head);
    frm_wdata     = {cmd_q.sample_left, cmd_q.sample_right};
    frm_raddr     = slot_of(wrap_add(WW'(cursor_rd), WW'(cmd_q.frame_offset)));
    head_next     = head;
    attached_next = attached;
    status_next   = status_q;
    peek_ok_next  = peek_ok;
    load_res      = 1'b0;
    unique case (state)
      S_IDLE: begin
        cmd_stall = rst;
      end
      S_LOOK: begin
        status_next  = ST_DONE;
        peek_ok_next = 1'b0;
        unique case (mode_t'(cmd_q.mode))
          MODE_WRITE: begin
            // pace to the slowest attached reader; drop on a full ring
            if (full) begin
              status_next = ST_FULL;
            end else begin
              frm_we    = 1'b1;
              head_next = wrap_add(WW'(head), WW'(1));
            end
          end
          MODE_PEEK: begin
            if (WW'(cmd_q.frame_offset) >= WW'(bl_c)) begin
              status_next = ST_PEEK_MISS;
            end else begin
              peek_ok_next = 1'b1;
              frm_re       = 1'b1;
            end
          end
          MODE_ADVANCE: begin
            // clamp to what the reader has; stop at the head
            if (adv_cnt > WW'(bl_c)) status_next = ST_CLAMP;
            if (c_att) begin
              cur_we    = 1'b1;
              cur_wdata = wrap_add(WW'(cursor_rd), adv_n);
            end
          end
          MODE_ATTACH: begin
            if (cons_ok) begin
              cur_we              = 1'b1;
              cur_wdata           = head;
              attached_next[cidx] = 1'b1;
            end
          end
          MODE_DETACH: begin
            if (cons_ok) attached_next[cidx] = 1'b0;
          end
          default: begin
          end
        endcase
      end
      S_SCAN: begin
        cur_raddr = scan_k[RW-1:0];
      end
      S_FINISH: begin
        load_res = res_free;
      end
      default: begin
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      head      <= '0;
      attached  <= '0;
      used_max  <= '0;
      res_valid <= 1'b0;
    end else begin
      state    <= state_next;
      head     <= head_next;
      attached <= attached_next;
      if (state == S_FINISH) used_max <= scan_acc;
      if (load_res) begin
        res_valid <= 1'b1;
      end else if (!res_stall) begin
        res_valid <= 1'b0;
      end
    end
  end

  // Item, scan and result registers
  always_ff @(posedge clk) begin
    if (cmd_accept) cmd_q <= cmd;
    status_q <= status_next;
    peek_ok  <= peek_ok_next;
    if (state == S_LOOK) begin
      scan_k   <= '0;
      scan_acc <= '0;
      avail_q  <= '0;
    end
    if (state == S_SCAN) begin
      scan_k <= scan_k + KW'(1);
      // frame read issued in the lookup cycle lands here
      if (scan_k == '0) begin
        data_l <= peek_ok ? frame_rd[2*SAMPLE_W-1:SAMPLE_W] : '0;
        data_r <= peek_ok ? frame_rd[SAMPLE_W-1:0] : '0;
      end else begin
        scan_acc <= acc_next;
        if (cons_ok && (j_idx == cidx)) avail_q <= bl_j;
      end
    end
    if (load_res) begin
      res.status           <= status_q;
      res.data_left        <= data_l;
      res.data_right       <= data_r;
      res.frames_available <= avail_w[COUNT_W-1:0];
      res.free_space       <= free_w[COUNT_W-1:0];
      res.reader_attached  <= c_att;
    end
  end

  // Cursor memory: one write, one registered read per cycle
  always_ff @(posedge clk) begin
    if (cur_we) cursor_mem[cur_waddr] <= cur_wdata;
    cursor_rd <= cursor_mem[cur_raddr];
  end

  // Frame memory: left sample in the upper half
  always_ff @(posedge clk) begin
    if (frm_we) frame_store[frm_waddr] <= frm_wdata;
    if (frm_re) frame_rd <= frame_store[frm_raddr];
  end

endmodule

>>> design/mrfr_checker.sv
// Port-level checks for the multi-reader frame ring, bound to the top level.
// Depends on mrfr_pkg and assert_macros.svh.
`include "assert_macros.svh"

module mrfr_checker (
  input logic           clk,
  input logic           rst,
  input logic           cmd_valid,
  input logic           cmd_stall,
  input logic           res_valid,
  input logic           res_stall,
  input mrfr_pkg::res_t res
);
  import mrfr_pkg::*;

  // hold a stalled result and its payload
  `ASSERT_NEXT(a_res_hold, clk, rst, res_valid && res_stall, res_valid)
  `ASSERT_NEXT(a_res_stable, clk, rst, res_valid && res_stall, $stable(res))
  // an accepted item keeps the block busy in the next cycle
  `ASSERT_NEXT(a_busy_after_accept, clk, rst, cmd_valid && !cmd_stall, cmd_stall)
  // a new result only comes out of work in progress
  `ASSERT_NOW(a_res_from_work, clk, rst, $rose(res_valid), $past(cmd_stall))

endmodule

bind multi_reader_frame_ring mrfr_checker u_mrfr_checker (
  .clk       (clk),
  .rst       (rst),
  .cmd_valid (cmd_valid),
  .cmd_stall (cmd_stall),
  .res_valid (res_valid),
  .res_stall (res_stall),
  .res       (res)
);
